// ===== rtl/swr_pkg.sv =====
// swr_pkg: shared constants and types for the swap readahead window block
// no dependencies; used by every module under rtl

package swr_pkg;

    // default parameter values for the top level
    localparam int MAX_WINDOW_DEF = 8;
    localparam int PAGE_BITS_DEF  = 36;

    // fixed field widths
    localparam int HITS_W = 8;
    localparam int ROOM_W = 4;
    localparam int WIN_W  = 4;

    // reset value of the max_window register
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 4'd8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // run description handed from front to back (page travels beside it)
    typedef struct packed {
        logic             up;
        logic [WIN_W-1:0] count;
    } swr_cmd_t;

endpackage

// ===== rtl/swap_readahead_window_top.sv =====
// swap_readahead_window_top: top level of the swap readahead window block
// depends on swr_pkg, swr_front, swr_queue, swr_back
//
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    s_tdata: fault_page, hits, queue_room
// m_       out  m_tvalid / m_tready    m_tdata: prefetch_page; m_tlast: last
// cfg_     in   cfg_valid / cfg_ready  cfg_data: max_window
//
// a fault is taken whenever the run queue has a free entry
// the walker loads a run from the queue, then emits one page per cycle
// while m_tready does not stall the output register
// m_ holds its transfer while m_tready is low; the queue absorbs two runs
// reset clears the state, the queue and sets max_window to 8

module swap_readahead_window_top #(
    parameter int MAX_WINDOW = swr_pkg::MAX_WINDOW_DEF,
    parameter int PAGE_BITS  = swr_pkg::PAGE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swr_pkg::WIN_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fault_page, hits, queue_room, zero fill
    input  logic [((PAGE_BITS+swr_pkg::HITS_W+swr_pkg::ROOM_W+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // prefetch_page, zero fill
    output logic [((PAGE_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int HW    = swr_pkg::HITS_W;
    localparam int RW    = swr_pkg::ROOM_W;
    localparam int OUT_W = ((PAGE_BITS + 7) / 8) * 8;
    localparam int QW    = PAGE_BITS + $bits(swr_pkg::swr_cmd_t);

    logic                     push;
    logic                     pop;
    logic                     full;
    logic                     empty;
    logic [PAGE_BITS-1:0]     push_page;
    swr_pkg::swr_cmd_t        push_cmd;
    logic [QW-1:0]            rd_data;
    logic [PAGE_BITS-1:0]     run_page;
    swr_pkg::swr_cmd_t        run_cmd;
    logic [PAGE_BITS-1:0]     out_page;

    // window computation and state
    swr_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PAGE_BITS  (PAGE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .fault_page (s_tdata[PAGE_BITS-1:0]),
        .hits       (s_tdata[PAGE_BITS+HW-1:PAGE_BITS]),
        .queue_room (s_tdata[PAGE_BITS+HW+RW-1:PAGE_BITS+HW]),
        .push       (push),
        .full       (full),
        .push_page  (push_page),
        .push_cmd   (push_cmd)
    );

    // run queue between front and back
    swr_queue #(
        .WIDTH   (QW),
        .DEPTH   (swr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_cmd, push_page}),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .empty   (empty)
    );

    assign run_page = rd_data[PAGE_BITS-1:0];
    assign run_cmd  = rd_data[QW-1:PAGE_BITS];

    // prefetch page walker
    swr_back #(
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .run_page  (run_page),
        .run_cmd   (run_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_page  (out_page),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'(out_page);

endmodule

// ===== rtl/swr_front.sv =====
// swr_front: accepts fault transfers, computes the readahead window and
// keeps the previous page and window; depends on swr_pkg

module swr_front #(
    parameter int MAX_WINDOW = swr_pkg::MAX_WINDOW_DEF,
    parameter int PAGE_BITS  = swr_pkg::PAGE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [swr_pkg::WIN_W-1:0]    cfg_data,
    // fault fields
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [PAGE_BITS-1:0]         fault_page,
    input  logic [swr_pkg::HITS_W-1:0]   hits,
    input  logic [swr_pkg::ROOM_W-1:0]   queue_room,
    // queue write side
    output logic                         push,
    input  logic                         full,
    output logic [PAGE_BITS-1:0]         push_page,
    output swr_pkg::swr_cmd_t            push_cmd
);

    localparam int WW = swr_pkg::WIN_W;
    localparam logic [WW-1:0] CAP_LIM = WW'((MAX_WINDOW > 15) ? 15 : MAX_WINDOW);

    logic [WW-1:0]        max_window_reg;
    logic [PAGE_BITS-1:0] prev_page_reg;
    logic [WW-1:0]        prev_win_reg;

    logic                 accept;
    logic                 up;
    logic                 adjacent;
    logic [PAGE_BITS-1:0] prev_inc;
    logic [PAGE_BITS-1:0] prev_dec;
    logic [WW:0]          raw_win;
    logic [WW-1:0]        cap;
    logic [WW-1:0]        capped_win;
    logic [WW-1:0]        half_prev;
    logic [WW-1:0]        win;
    logic [WW:0]          room_plus;
    logic [WW-1:0]        used;
    logic [WW-1:0]        count;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;

    // direction and adjacency against the previous fault
    assign up       = fault_page > prev_page_reg;
    assign prev_inc = prev_page_reg + PAGE_BITS'(1);
    assign prev_dec = prev_page_reg - PAGE_BITS'(1);
    assign adjacent = (fault_page == prev_inc) || (fault_page == prev_dec);

    // window from hits, clipped at 16 since the cap never exceeds 15
    always_comb
    begin
        if (hits == '0)
            raw_win = adjacent ? (WW+1)'(2) : (WW+1)'(1);
        else if (hits <= swr_pkg::HITS_W'(2))
            raw_win = (WW+1)'(4);
        else if (hits <= swr_pkg::HITS_W'(6))
            raw_win = (WW+1)'(8);
        else
            raw_win = (WW+1)'(16);
    end

    // configured cap, limited to the build maximum and at least one
    always_comb
    begin
        cap = (max_window_reg > CAP_LIM) ? CAP_LIM : max_window_reg;
        if (cap == '0)
            cap = WW'(1);
    end

    // cap, floor at half the previous window, then limit by queue room
    always_comb
    begin
        capped_win = (raw_win > {1'b0, cap}) ? cap : raw_win[WW-1:0];
        half_prev  = prev_win_reg >> 1;
        win        = (capped_win < half_prev) ? half_prev : capped_win;
        room_plus  = {1'b0, queue_room} + (WW+1)'(1);
        used       = ({1'b0, win} > room_plus) ? room_plus[WW-1:0] : win;
        count      = used - WW'(1);
    end

    // run goes to the queue only when it emits something
    assign push           = accept && (count != '0);
    assign push_page      = fault_page;
    assign push_cmd.up    = up;
    assign push_cmd.count = count;

    // configuration register and per-fault state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_window_reg <= swr_pkg::MAX_WINDOW_RST;
            prev_page_reg  <= '0;
            prev_win_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_window_reg <= cfg_data;
            if (accept)
            begin
                prev_page_reg <= fault_page;
                prev_win_reg  <= used;
            end
        end
    end

endmodule

// ===== rtl/swr_queue.sv =====
// swr_queue: short register queue carrying runs from front to back
// depends on swr_pkg for the default depth

module swr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = swr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    fill_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    fill_next;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            fill_next = fill_reg + CW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");
    a_fill_step : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("queue fill did not follow a lone write");
`endif

endmodule

// ===== rtl/swr_back.sv =====
// swr_back: walks one run at a time, one prefetch page per transfer
// depends on swr_pkg for the run description

module swr_back #(
    parameter int PAGE_BITS = swr_pkg::PAGE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // queue read side
    input  logic                  empty,
    output logic                  pop,
    input  logic [PAGE_BITS-1:0]  run_page,
    input  swr_pkg::swr_cmd_t     run_cmd,
    // result register
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PAGE_BITS-1:0]  out_page,
    output logic                  out_last
);

    localparam int WW = swr_pkg::WIN_W;

    logic                 busy_reg;
    logic                 up_reg;
    logic [WW-1:0]        left_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 out_valid_reg;
    logic [PAGE_BITS-1:0] out_page_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 step;
    logic [PAGE_BITS-1:0] page_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign step      = busy_reg && out_free;
    assign pop       = !busy_reg && !empty;
    assign page_next = up_reg ? page_reg + PAGE_BITS'(1) : page_reg - PAGE_BITS'(1);

    assign out_valid = out_valid_reg;
    assign out_page  = out_page_reg;
    assign out_last  = out_last_reg;

    // run walker control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                left_reg <= run_cmd.count;
            end
            else if (step)
            begin
                busy_reg <= (left_reg != WW'(1));
                left_reg <= left_reg - WW'(1);
            end
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // run payload and result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            page_reg <= run_page;
            up_reg   <= run_cmd.up;
        end
        else if (step)
            page_reg <= page_next;
        if (step)
        begin
            out_page_reg <= page_next;
            out_last_reg <= (left_reg == WW'(1));
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_has_work : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("walker busy with no pages left");
    a_last_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
        (step && (left_reg == WW'(1))) |=> (!busy_reg && out_last_reg))
        else $error("final page did not end the run");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for swap_readahead_window_top
// depends on swr_pkg and the rtl top; predicts each prefetch run and checks every transfer
`timescale 1ns / 1ps

module testbench;

    localparam int HITS_W         = swr_pkg::HITS_W;
    localparam int ROOM_W         = swr_pkg::ROOM_W;
    localparam int WIN_W          = swr_pkg::WIN_W;
    localparam int MAX_WINDOW_DEF = swr_pkg::MAX_WINDOW_DEF;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST = swr_pkg::MAX_WINDOW_RST;

    localparam int PAGE_BITS    = swr_pkg::PAGE_BITS_DEF;
    localparam int S_DATA_W     = ((PAGE_BITS + HITS_W + ROOM_W + 7) / 8) * 8;
    localparam int M_DATA_W     = ((PAGE_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 32;
    localparam int TIMEOUT_NS   = 4000000;
    localparam logic [PAGE_BITS-1:0] TOP_PAGE = {PAGE_BITS{1'b1}};

    // one page fault, page in the lowest bits as on s_tdata
    typedef struct packed {
        logic [ROOM_W-1:0]    room;
        logic [HITS_W-1:0]    hits;
        logic [PAGE_BITS-1:0] page;
    } fault_item_t;

    // one predicted prefetch transfer
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 last;
    } prefetch_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [WIN_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;

    // stimulus and expectation stores
    fault_item_t pending_faults[$];
    prefetch_t   expected_prefetch[$];
    prefetch_t   next_prefetch;

    // predictor copy of the block state and register
    logic [PAGE_BITS-1:0] last_fault_page = '0;
    logic [WIN_W-1:0]     last_window     = '0;
    logic [WIN_W-1:0]     window_limit    = MAX_WINDOW_RST;

    // page the generator last queued, to build runs of nearby faults
    logic [PAGE_BITS-1:0] gen_page = '0;

    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;
    int error_count        = 0;
    int faults_sent        = 0;
    int prefetches_checked = 0;
    int limit_writes       = 0;

    swap_readahead_window_top #(
        .MAX_WINDOW (MAX_WINDOW_DEF),
        .PAGE_BITS  (PAGE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // window and prefetch pages for one accepted fault
    function automatic void predict_prefetch(fault_item_t f);
        int win;
        int cap;
        int used;
        logic up;
        prefetch_t pf;
        up  = f.page > last_fault_page;
        win = int'(f.hits) + 2;
        if (f.hits == 0)
        begin
            // zero hits: two pages only for a neighbor of the last fault
            if (f.page != last_fault_page + 1'b1 && f.page != last_fault_page - 1'b1)
            begin
                win = 1;
            end
        end
        else
        begin
            cap = 4;
            while (cap < win)
            begin
                cap = cap << 1;
            end
            win = cap;
        end
        // register limit, zero acting as one and large values as the maximum
        cap = int'(window_limit);
        if (cap > MAX_WINDOW_DEF)
        begin
            cap = MAX_WINDOW_DEF;
        end
        if (cap == 0)
        begin
            cap = 1;
        end
        if (win > cap)
        begin
            win = cap;
        end
        if (win < int'(last_window) / 2)
        begin
            win = int'(last_window) / 2;
        end
        used = win;
        if (used > int'(f.room) + 1)
        begin
            used = int'(f.room) + 1;
        end
        for (int i = 1; i < used; i++)
        begin
            pf.page = up ? f.page + PAGE_BITS'(i) : f.page - PAGE_BITS'(i);
            pf.last = (i == used - 1);
            expected_prefetch.push_back(pf);
        end
        last_fault_page = f.page;
        last_window     = WIN_W'(used);
    endfunction

    // fault driver: holds each transfer until accepted, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_prefetch(fault_item_t'(s_tdata));
                faults_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_faults.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_faults.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // prefetch monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_prefetch.size() == 0)
            begin
                $error("unexpected prefetch transfer page %h last %b",
                       m_tdata[PAGE_BITS-1:0], m_tlast);
                error_count++;
            end
            else
            begin
                next_prefetch = expected_prefetch.pop_front();
                if (m_tdata[PAGE_BITS-1:0] !== next_prefetch.page)
                begin
                    $error("prefetch_page expected %h actual %h",
                           next_prefetch.page, m_tdata[PAGE_BITS-1:0]);
                    error_count++;
                end
                if (m_tlast !== next_prefetch.last)
                begin
                    $error("last expected %b actual %b", next_prefetch.last, m_tlast);
                    error_count++;
                end
                prefetches_checked++;
            end
        end
    end

    task automatic push_fault(logic [PAGE_BITS-1:0] page, int hits, int room);
        fault_item_t f;
        f.page = page;
        f.hits = HITS_W'(hits);
        f.room = ROOM_W'(room);
        pending_faults.push_back(f);
        gen_page = page;
    endtask

    // wait until every fault went in and every prefetch came out, then let the walker settle
    task automatic wait_drained();
        while (pending_faults.size() != 0 || s_tvalid || expected_prefetch.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic set_window_limit(int value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= WIN_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_limit = WIN_W'(value);
        limit_writes++;
    endtask

    // runs of neighboring faults most often, with jumps, random pages, repeats and wrap edges mixed in
    task automatic queue_random_faults(int count);
        int kind;
        int hits;
        int room;
        int pick;
        logic [PAGE_BITS-1:0] page;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(8);
            pick = $urandom_range(9);
            if (pick < 3)
            begin
                hits = 0;
            end
            else if (pick < 7)
            begin
                hits = $urandom_range(6, 1);
            end
            else if (pick < 9)
            begin
                hits = $urandom_range(40, 7);
            end
            else
            begin
                hits = $urandom_range(255, 41);
            end
            room = ($urandom_range(3) == 0) ? 8 : $urandom_range(8);
            case (kind)
                0, 1, 2, 3:
                begin
                    page = $urandom_range(1) ? gen_page + 1'b1 : gen_page - 1'b1;
                    if ($urandom_range(1))
                    begin
                        hits = 0;
                    end
                end
                4, 5:
                begin
                    page = $urandom_range(1) ? gen_page + PAGE_BITS'($urandom_range(40, 2))
                                             : gen_page - PAGE_BITS'($urandom_range(40, 2));
                end
                6:
                begin
                    page = gen_page;
                end
                7:
                begin
                    page = {4'($urandom_range(15)), 32'($urandom())};
                end
                default:
                begin
                    page = $urandom_range(1) ? TOP_PAGE - PAGE_BITS'($urandom_range(3))
                                             : PAGE_BITS'($urandom_range(3));
                end
            endcase
            push_fault(page, hits, room);
        end
    endtask

    task automatic run_phase(int limit, int send_pct, int recv_pct, int count);
        set_window_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_faults(count);
    endtask

    // reset, directed faults, then random phases
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // register at its reset value: adjacency, same page, wraps, no room, partial room
        push_fault(36'd1, 0, 8);
        push_fault(36'd1, 5, 8);
        push_fault(36'd0, 0, 8);
        push_fault(TOP_PAGE, 255, 8);
        push_fault(36'd0, 0, 8);
        push_fault(36'd100, 1, 0);
        push_fault(36'd200, 0, 8);
        push_fault(36'd300, 2, 2);
        push_fault(36'd50, 3, 8);
        push_fault(36'd60, 1, 8);
        push_fault(36'h5_A5A5_A5A5, 6, 8);
        push_fault(36'hA_5A5A_5A5A, 7, 4);

        // zero limit acts as one, half the last window still wins
        set_window_limit(0);
        push_fault(36'd1000, 255, 8);
        push_fault(36'd1001, 0, 8);

        // oversized limit acts as the maximum
        set_window_limit(15);
        push_fault(36'd2000, 30, 8);
        push_fault(36'd1999, 0, 8);

        set_window_limit(1);
        push_fault(36'd3000, 4, 8);

        run_phase(8, 0, 0, 60);
        run_phase(4, 76, 0, 60);
        run_phase(1, 0, 76, 50);
        run_phase(15, 36, 36, 60);
        run_phase(0, 0, 0, 40);
        run_phase(2, 36, 36, 60);
        run_phase($urandom_range(7, 3), 76, 0, 70);
        run_phase(8, 0, 76, 70);
        wait_drained();

        $display("covered %0d faults and %0d checked prefetch transfers", faults_sent,
                 prefetches_checked);
        $display("over %0d window limit writes with sender gaps and receiver stalls",
                 limit_writes);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // run time limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d faults pending and %0d prefetches outstanding",
                 pending_faults.size(), expected_prefetch.size());
        $display("FAILURE");
        $finish;
    end

endmodule
